@@ hdl/ssd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment decoder for the seven-segment
// shift-register driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam logic [1:0] REQ_NUMBER    = 2'd0;
	localparam logic [1:0] REQ_SYMBOL    = 2'd1;
	localparam logic [1:0] REQ_SYMBOL_DP = 2'd2;
	localparam logic [1:0] REQ_CLEAR     = 2'd3;

	localparam logic [3:0]  BLANK_CODE    = 4'd12;
	localparam logic [7:0]  DOT_MASK      = 8'h01;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
	localparam logic [13:0] NUM_MAX       = 14'd9999;
	localparam logic [13:0] SYM_MAX       = 14'd12;
	localparam logic [1:0]  LAST_DIGIT    = 2'd3;

	// v / 10 == (v * 52429) >> 19 for v < 43699
	localparam logic [15:0] RECIP_10      = 16'd52429;
	localparam int          RECIP_SHIFT   = 19;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef struct packed {
		logic [7:0] pattern;
		logic       last;
	} ssd_pat_t;

	function automatic logic [7:0] seg_decode(input logic [3:0] code);
		logic [7:0] pat;
		unique case (code)
			4'd0:    pat = 8'd252;
			4'd1:    pat = 8'd96;
			4'd2:    pat = 8'd218;
			4'd3:    pat = 8'd242;
			4'd4:    pat = 8'd102;
			4'd5:    pat = 8'd182;
			4'd6:    pat = 8'd190;
			4'd7:    pat = 8'd224;
			4'd8:    pat = 8'd254;
			4'd9:    pat = 8'd246;
			4'd10:   pat = 8'd1;
			4'd11:   pat = 8'd2;
			default: pat = 8'd0;
		endcase
		return pat;
	endfunction

endpackage

@@ hdl/seven_segment_shift_driver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_shift_driver_top
// Seven-segment shift-register driver: requests in, serial bit / latch
// items out.
// ----------------------------------------------------------------------------
// A number or clear request yields 36 items (four patterns of eight data bits
// plus a latch strobe each, ones digit first); a symbol request yields 9. The
// serializer delivers one item per cycle while pop is held high and a pattern
// is queued, paced by its one-bit-per-cycle shifter. The front end converts a
// number one digit per cycle, while the queue has room, into a four-deep
// pattern queue and holds full high until all patterns of the request are
// queued, so the next request is taken while the previous one is still being
// shifted out. The first item of an idle block passes the front-end request
// registers, the queue, the pattern register and the output register.
// ----------------------------------------------------------------------------
module seven_segment_shift_driver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [13:0] operand,
	output logic        empty,
	input  logic        pop,
	output logic        data_bit,
	output logic        latch_pulse,
	output logic        last
);

	ssd_pkg::ssd_pat_t wr_data;
	ssd_pkg::ssd_pat_t rd_data;
	logic              wr_en;
	logic              wr_full;
	logic              rd_en;
	logic              rd_empty;

	ssd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.operand  (operand),
		.q_push   (wr_en),
		.q_data   (wr_data),
		.q_full   (wr_full)
	);

	ssd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.wr_full  (wr_full),
		.rd_en    (rd_en),
		.rd_data  (rd_data),
		.rd_empty (rd_empty)
	);

	ssd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_pop       (rd_en),
		.q_data      (rd_data),
		.q_empty     (rd_empty),
		.empty       (empty),
		.pop         (pop),
		.data_bit    (data_bit),
		.latch_pulse (latch_pulse),
		.last        (last)
	);

endmodule

@@ hdl/ssd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_front
// Takes requests, splits numbers into decimal digits one per cycle and pushes
// one segment pattern per cycle into the pattern queue while it has room.
// ----------------------------------------------------------------------------
module ssd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       req_type,
	input  logic [13:0]      operand,
	output logic             q_push,
	output ssd_pkg::ssd_pat_t q_data,
	input  logic             q_full
);

	logic        busy_q;
	logic [1:0]  kind_q;
	logic [13:0] val_q;
	logic [1:0]  idx_q;

	logic        accept;
	logic [29:0] prod;
	logic [10:0] quot;
	logic [13:0] quot_x10;
	logic [3:0]  rem;
	logic [3:0]  code;
	logic [7:0]  pat;
	logic        last;

	assign full   = busy_q;
	assign accept = push && !busy_q;

	assign prod     = 30'(val_q) * 30'(ssd_pkg::RECIP_10);
	assign quot     = prod[29:ssd_pkg::RECIP_SHIFT];
	assign quot_x10 = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
	assign rem      = 4'(val_q - quot_x10);

	always_comb begin
		case (kind_q)
			ssd_pkg::REQ_NUMBER: begin
				// higher digits blank once nothing is left of the number
				code = (idx_q == 2'd0 || val_q != 14'd0) ? rem : ssd_pkg::BLANK_CODE;
				last = (idx_q == ssd_pkg::LAST_DIGIT);
			end
			ssd_pkg::REQ_CLEAR: begin
				code = ssd_pkg::BLANK_CODE;
				last = (idx_q == ssd_pkg::LAST_DIGIT);
			end
			default: begin
				code = val_q[3:0];
				last = 1'b1;
			end
		endcase
		pat = ssd_pkg::seg_decode(code);
		if (kind_q == ssd_pkg::REQ_SYMBOL_DP)
			pat = pat ^ ssd_pkg::DOT_MASK;
	end

	assign q_push         = busy_q && !q_full;
	assign q_data.pattern = pat;
	assign q_data.last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (q_push && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req_type;
			idx_q  <= 2'd0;
			if (req_type == ssd_pkg::REQ_NUMBER)
				val_q <= (operand > ssd_pkg::NUM_MAX) ? ssd_pkg::NUM_MAX : operand;
			else
				val_q <= (operand > ssd_pkg::SYM_MAX) ? ssd_pkg::SYM_MAX : operand;
		end else if (q_push) begin
			val_q <= 14'(quot);
			idx_q <= idx_q + 2'd1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("pattern pushed into full queue");
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == ssd_pkg::REQ_NUMBER |-> val_q <= ssd_pkg::NUM_MAX)
		else $error("number out of range");
	a_symbol_single: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && (kind_q == ssd_pkg::REQ_SYMBOL || kind_q == ssd_pkg::REQ_SYMBOL_DP)
		|=> !busy_q) else $error("symbol request produced more than one pattern");

endmodule

@@ hdl/ssd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_fifo
// Short pattern queue between the request front end and the serializer.
// ----------------------------------------------------------------------------
module ssd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ssd_pkg::ssd_pat_t wr_data,
	output logic              wr_full,
	input  logic              rd_en,
	output ssd_pkg::ssd_pat_t rd_data,
	output logic              rd_empty
);

	ssd_pkg::ssd_pat_t                 mem_q [ssd_pkg::FIFO_DEPTH];
	logic [ssd_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [ssd_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [ssd_pkg::FIFO_CW-1:0]       count_q;

	logic do_wr;
	logic do_rd;

	assign wr_full  = (count_q == ssd_pkg::FIFO_CW'(ssd_pkg::FIFO_DEPTH));
	assign rd_empty = (count_q == '0);
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && !rd_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ssd_pkg::FIFO_CW'(ssd_pkg::FIFO_DEPTH)) else $error("queue overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != ssd_pkg::FIFO_CW'(ssd_pkg::FIFO_DEPTH) |->
		ssd_pkg::FIFO_AW'(wr_ptr_q - rd_ptr_q) == ssd_pkg::FIFO_AW'(count_q))
		else $error("queue pointers disagree with count");
	a_rd_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_empty |=> $stable(rd_ptr_q)) else $error("read from empty queue");

endmodule

@@ hdl/ssd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_back
// Serializer: shifts each queued pattern out LSB first, one bit per item,
// then a latch strobe item, into a one-entry output register.
// ----------------------------------------------------------------------------
module ssd_back (
	input  logic              clk,
	input  logic              arst_n,
	output logic              q_pop,
	input  ssd_pkg::ssd_pat_t q_data,
	input  logic              q_empty,
	output logic              empty,
	input  logic              pop,
	output logic              data_bit,
	output logic              latch_pulse,
	output logic              last
);

	logic       active_q;
	logic [7:0] pat_q;
	logic       last_q;
	logic [3:0] cnt_q;

	logic       out_valid_q;
	logic       out_data_q;
	logic       out_latch_q;
	logic       out_last_q;

	logic step;
	logic at_latch;
	logic load;

	assign step     = active_q && (!out_valid_q || pop);
	assign at_latch = (cnt_q == ssd_pkg::BITS_PER_BYTE);
	// next pattern is taken in the same cycle as the latch strobe goes out
	assign load     = !q_empty && (!active_q || (step && at_latch));
	assign q_pop    = load;

	assign empty       = !out_valid_q;
	assign data_bit    = out_data_q;
	assign latch_pulse = out_latch_q;
	assign last        = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;

			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= 4'd0;
			end else if (step) begin
				if (at_latch)
					active_q <= 1'b0;
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q  <= at_latch ? 1'b0 : pat_q[0];
			out_latch_q <= at_latch;
			out_last_q  <= at_latch && last_q;
		end
		if (load) begin
			pat_q  <= q_data.pattern;
			last_q <= q_data.last;
		end else if (step) begin
			pat_q  <= {1'b0, pat_q[7:1]};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q <= ssd_pkg::BITS_PER_BYTE) else $error("bit count out of range");
	a_last_on_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_latch_q) else $error("last flag off a latch item");
	a_latch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_latch_q |-> !out_data_q) else $error("data set on latch item");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q) else $error("result dropped");

endmodule
